// ===== rtl/zcnn_pkg.sv =====
// Shared types, widths and constants of the z-score class nearest-neighbor block.
package zcnn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FEATURES   = 4;
    localparam int FEAT_W     = 16;
    localparam int CLASS_W    = 3;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int WORD_W     = 4 * FEAT_W + CLASS_W;
    localparam int SUM_W      = FEAT_W + CNT_W;
    localparam int DEV_W      = SUM_W + 1;
    localparam int SQ_W       = 2 * DEV_W;
    localparam int SCAT_W     = SQ_W + IDX_W;
    localparam int N3_W       = 3 * CNT_W;
    localparam int DX_W       = FEAT_W + 1;
    localparam int DX2_W      = 2 * FEAT_W;
    localparam int PROD_W     = N3_W + DX2_W;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = FRAC_W + CNT_W + 1;
    localparam int LOW_W      = QUO_W - FRAC_W;
    localparam int CONTRIB_W  = DX2_W;
    localparam int ACC_W      = CONTRIB_W + 2;
    localparam int ROOT_W     = ACC_W / 2;
    localparam int DIST_W     = 16;
    localparam int PIDX_W     = 6;

    localparam logic [DIST_W-1:0] DIST_SAT   = '1;
    localparam logic [DIST_W-1:0] KEEP_RESET = 16'd256;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_a;
        logic signed [FEAT_W-1:0] feature_b;
        logic signed [FEAT_W-1:0] feature_c;
        logic signed [FEAT_W-1:0] feature_d;
        logic [CLASS_W-1:0]       class_id;
        logic                     final_point;
    } in_t;

    typedef struct packed {
        logic [PIDX_W-1:0] point_index;
        logic [DIST_W-1:0] nearest_distance;
        logic              kept;
        logic              raw_used;
        logic              last_result;
    } out_t;

    typedef struct packed {
        logic clear;
        logic load_en;
        logic scat_en;
        logic pair_start;
        logic raw;
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic zero;
    } lane_st_t;

endpackage

// ===== rtl/zcnn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module zcnn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/zcnn_lane.sv =====
// One feature lane: running sum, scatter, and per-pair squared difference (normalized unless raw).
module zcnn_lane
    import zcnn_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctl_t                ctl,
    input  logic signed [FEAT_W-1:0] x_load,
    input  logic signed [FEAT_W-1:0] x_ram,
    input  logic signed [FEAT_W-1:0] xi,
    input  logic [CNT_W-1:0]         n,
    input  logic [N3_W-1:0]          n3,
    output lane_st_t                 st,
    output logic [CONTRIB_W-1:0]     contrib
);

    localparam int CW = $clog2(QUO_W);

    typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL, L_DIV} lstate_t;

    lstate_t                   state_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [DEV_W-1:0]   dev_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [SCAT_W-1:0]         scat_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [DX_W-1:0]    dx_reg;
    logic [DX2_W-1:0]          dx2_reg;
    logic [SCAT_W-1:0]         rem_reg;
    logic [QUO_W-1:0]          sh_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic [CW-1:0]             cnt_reg;
    logic [CONTRIB_W-1:0]      contrib_reg;

    logic signed [DEV_W-1:0]   nx;
    logic signed [DEV_W-1:0]   dev_next;
    logic signed [SQ_W-1:0]    sq_full;
    logic signed [2*DX_W-1:0]  dx2_full;
    logic [PROD_W-1:0]         prod;
    logic [SCAT_W:0]           trial;
    logic [SCAT_W:0]           diff;
    logic                      ge;

    assign nx       = $signed({1'b0, n}) * x_ram;
    assign dev_next = nx - DEV_W'(sum_reg);
    assign sq_full  = dev_reg * dev_reg;
    assign dx2_full = dx_reg * dx_reg;
    assign prod     = PROD_W'(n3) * PROD_W'(dx2_reg);
    assign trial    = {rem_reg, sh_reg[QUO_W-1]};
    assign diff     = trial - {1'b0, scat_reg};
    assign ge       = trial >= {1'b0, scat_reg};

    assign st.busy  = (state_reg != L_IDLE);
    assign st.zero  = (scat_reg == '0);
    assign contrib  = contrib_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            sum_reg   <= '0;
            scat_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            v1_reg <= ctl.scat_en;
            v2_reg <= v1_reg;
            if (ctl.scat_en) begin
                dev_reg <= dev_next;
            end
            if (v1_reg) begin
                sq_reg <= SQ_W'(unsigned'(sq_full));
            end
            if (ctl.clear) begin
                sum_reg  <= '0;
                scat_reg <= '0;
            end else begin
                if (ctl.load_en) begin
                    sum_reg <= sum_reg + SUM_W'(x_load);
                end
                if (v2_reg) begin
                    scat_reg <= scat_reg + SCAT_W'(sq_reg);
                end
            end

            case (state_reg)
                L_IDLE: begin
                    if (ctl.pair_start) begin
                        dx_reg    <= DX_W'(xi) - DX_W'(x_ram);
                        state_reg <= L_SQ;
                    end
                end
                L_SQ: begin
                    dx2_reg   <= dx2_full[DX2_W-1:0];
                    state_reg <= L_MUL;
                end
                L_MUL: begin
                    if (ctl.raw) begin
                        contrib_reg <= CONTRIB_W'(dx2_reg);
                        state_reg   <= L_IDLE;
                    end else begin
                        rem_reg   <= SCAT_W'(prod >> LOW_W);
                        sh_reg    <= {prod[LOW_W-1:0], {FRAC_W{1'b0}}};
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= L_DIV;
                    end
                end
                L_DIV: begin
                    rem_reg <= ge ? diff[SCAT_W-1:0] : trial[SCAT_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], ge};
                    sh_reg  <= sh_reg << 1;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(QUO_W - 1)) begin
                        contrib_reg <= CONTRIB_W'({quo_reg[QUO_W-2:0], ge});
                        state_reg   <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/zcnn_isqrt.sv =====
// Bit-serial integer square root of the nearest squared distance.
module zcnn_isqrt
    import zcnn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ACC_W-1:0]  value,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int BIT0 = ((ACC_W - 1) / 2) * 2;

    logic [ACC_W-1:0] v_reg;
    logic [ACC_W-1:0] res_reg;
    logic [ACC_W-1:0] bit_reg;
    logic             busy_reg;
    logic [ACC_W:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign busy  = busy_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            v_reg    <= value;
            res_reg  <= '0;
            bit_reg  <= ACC_W'(1) << BIT0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            if (bit_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                if ({1'b0, v_reg} >= trial) begin
                    v_reg   <= v_reg - trial[ACC_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

endmodule

// ===== rtl/zscore_class_nearest_neighbor.sv =====
// Top level: point store, sequencer, feature lanes, merge of lane results, output register.
//
// Points load at one transaction per cycle while s_ready is high. The transaction
// with final_point set starts the work, and s_ready stays low until the last result
// is loaded into the output register. Per data set of N points: a scatter pass over
// all N points, then per point a setup, a class check for each point that is not a
// classmate (the point itself included), a lane run for each classmate (the feature
// lanes run side by side, each with a divider that makes one quotient bit per cycle;
// the divider is skipped when raw values are used), and a square root when a
// classmate exists; the result is then emitted once the output register is free.
// For a large set of one class the lane dividers take most of the time.
module zscore_class_nearest_neighbor
    import zcnn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_wr_en,
    input  logic [DIST_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_LOAD, ST_SCAT, ST_DRAIN, ST_PT_READ, ST_PT_LATCH, ST_PR_READ,
        ST_PR_CHK, ST_PR_WAIT, ST_PR_CMP, ST_SQ_START, ST_SQ_WAIT, ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [2*CNT_W-1:0]   nsq_reg;
    logic [N3_W-1:0]      n3_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [IDX_W-1:0]     i_reg;
    logic [IDX_W-1:0]     j_reg;
    logic [1:0]           drain_reg;
    logic                 scat_rd_reg;
    logic                 raw_reg;
    logic [DIST_W-1:0]    keep_reg;
    logic [WORD_W-1:0]    pi_reg;
    logic                 found_reg;
    logic [ACC_W-1:0]     best_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    logic                     accept;
    logic                     store;
    logic [IDX_W-1:0]         raddr;
    logic [WORD_W-1:0]        rdata;
    logic [WORD_W-1:0]        wdata;
    lane_ctl_t                ctl;
    lane_st_t                 lst [FEATURES];
    logic [CONTRIB_W-1:0]     contrib [FEATURES];
    logic signed [FEAT_W-1:0] in_feat [4];
    logic [FEATURES-1:0]      busy_vec;
    logic [FEATURES-1:0]      zero_vec;
    logic                     busy_any;
    logic [ACC_W-1:0]         acc_sum;
    logic                     match;
    logic                     j_last;
    logic                     i_last;
    logic                     emit_go;
    logic                     sq_busy;
    logic [ROOT_W-1:0]        root;
    logic [DIST_W-1:0]        dist_val;

    assign s_ready = aresetn && (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;
    assign store   = accept && (count_reg < CNT_W'(MAX_POINTS));
    assign wdata   = {s_data.class_id, s_data.feature_d, s_data.feature_c,
                      s_data.feature_b, s_data.feature_a};

    assign in_feat[0] = s_data.feature_a;
    assign in_feat[1] = s_data.feature_b;
    assign in_feat[2] = s_data.feature_c;
    assign in_feat[3] = s_data.feature_d;

    always_comb begin
        case (state_reg)
            ST_SCAT:    raddr = k_reg;
            ST_PT_READ: raddr = i_reg;
            default:    raddr = j_reg;
        endcase
    end

    zcnn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (store),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign match   = (j_reg != i_reg) &&
                     (rdata[4*FEAT_W +: CLASS_W] == pi_reg[4*FEAT_W +: CLASS_W]);
    assign j_last  = (CNT_W'(j_reg) == n_reg - CNT_W'(1));
    assign i_last  = (CNT_W'(i_reg) == n_reg - CNT_W'(1));
    assign emit_go = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        ctl.clear      = emit_go && i_last;
        ctl.load_en    = store;
        ctl.scat_en    = scat_rd_reg;
        ctl.pair_start = (state_reg == ST_PR_CHK) && match;
        ctl.raw        = raw_reg;
    end

    for (genvar f = 0; f < FEATURES; f++) begin : g_lane
        zcnn_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .x_load  (in_feat[f]),
            .x_ram   (rdata[FEAT_W*f +: FEAT_W]),
            .xi      (pi_reg[FEAT_W*f +: FEAT_W]),
            .n       (n_reg),
            .n3      (n3_reg),
            .st      (lst[f]),
            .contrib (contrib[f])
        );
        assign busy_vec[f] = lst[f].busy;
        assign zero_vec[f] = lst[f].zero;
    end

    assign busy_any = |busy_vec;

    always_comb begin
        acc_sum = '0;
        for (int f = 0; f < FEATURES; f++) begin
            acc_sum = acc_sum + ACC_W'(contrib[f]);
        end
    end

    zcnn_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_SQ_START),
        .value   (best_reg),
        .busy    (sq_busy),
        .root    (root)
    );

    always_comb begin
        if (!found_reg || (|root[ROOT_W-1:DIST_W])) begin
            dist_val = DIST_SAT;
        end else begin
            dist_val = root[DIST_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            keep_reg    <= KEEP_RESET;
            scat_rd_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                keep_reg <= cfg_wr_data;
            end
            scat_rd_reg <= (state_reg == ST_SCAT);
            if (emit_go) begin
                m_valid_reg                 <= 1'b1;
                m_data_reg.point_index      <= PIDX_W'(i_reg);
                m_data_reg.nearest_distance <= dist_val;
                m_data_reg.kept             <= found_reg && (dist_val <= keep_reg);
                m_data_reg.raw_used         <= raw_reg;
                m_data_reg.last_result      <= i_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_LOAD: begin
                    if (store) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (accept && s_data.final_point) begin
                        n_reg     <= store ? count_reg + CNT_W'(1) : count_reg;
                        count_reg <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_SCAT;
                    end
                end
                ST_SCAT: begin
                    if (CNT_W'(k_reg) == n_reg - CNT_W'(1)) begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd0) begin
                        nsq_reg <= (2*CNT_W)'(n_reg) * (2*CNT_W)'(n_reg);
                    end
                    if (drain_reg == 2'd1) begin
                        n3_reg <= N3_W'(nsq_reg) * N3_W'(n_reg);
                    end
                    if (drain_reg == 2'd3) begin
                        raw_reg   <= |zero_vec;
                        i_reg     <= '0;
                        state_reg <= ST_PT_READ;
                    end
                end
                ST_PT_READ: begin
                    state_reg <= ST_PT_LATCH;
                end
                ST_PT_LATCH: begin
                    pi_reg    <= rdata;
                    found_reg <= 1'b0;
                    j_reg     <= '0;
                    state_reg <= ST_PR_READ;
                end
                ST_PR_READ: begin
                    state_reg <= ST_PR_CHK;
                end
                ST_PR_CHK: begin
                    if (match) begin
                        state_reg <= ST_PR_WAIT;
                    end else if (j_last) begin
                        state_reg <= found_reg ? ST_SQ_START : ST_EMIT;
                    end else begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= ST_PR_READ;
                    end
                end
                ST_PR_WAIT: begin
                    if (!busy_any) begin
                        acc_reg   <= acc_sum;
                        state_reg <= ST_PR_CMP;
                    end
                end
                ST_PR_CMP: begin
                    if (!found_reg || (acc_reg < best_reg)) begin
                        best_reg <= acc_reg;
                    end
                    found_reg <= 1'b1;
                    if (j_last) begin
                        state_reg <= ST_SQ_START;
                    end else begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= ST_PR_READ;
                    end
                end
                ST_SQ_START: begin
                    state_reg <= ST_SQ_WAIT;
                end
                ST_SQ_WAIT: begin
                    if (!sq_busy) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        if (i_last) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_PT_READ;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    a_lanes_idle_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !busy_any)
        else $error("feature lane busy while loading");

    a_sqrt_needs_classmate: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ_START) |-> found_reg)
        else $error("square root started without a classmate");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid_reg && !m_ready) |=> (state_reg == ST_EMIT))
        else $error("result dropped while output register full");

endmodule

// ===== sim/tb.sv =====
// Testbench for the z-score class nearest-neighbor block: directed table, random data sets, predictor check.
module tb;
    import zcnn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        in_t  pt;
        bit   typed;
        out_t want;
    } dir_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_t               s_data;
    logic              m_valid;
    logic              m_ready;
    out_t              m_data;
    logic              cfg_wr_en;
    logic [DIST_W-1:0] cfg_wr_data;

    out_t        nn_results_q[$];
    int          err_cnt;
    int          send_idle;
    int          recv_idle;
    int          hold_left;
    int          items_sent;
    dir_row_t    dir_tab[$];

    int          set_feat[MAX_POINTS][4];
    int          set_cls[MAX_POINTS];
    int          set_cnt;
    int          keep_lim;

    zscore_class_nearest_neighbor dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint unsigned frac_div(longint unsigned p, longint unsigned q);
        longint unsigned quo;
        longint unsigned rem;
        quo = p / q;
        rem = p % q;
        for (int k = 0; k < 16; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= q) begin
                rem = rem - q;
                quo = quo | 1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Store one point; on the final point, compute the nearest classmate of every point.
    task automatic predict_nearest(in_t p);
        longint          sum;
        longint          d;
        longint          dx;
        longint unsigned scat[4];
        longint unsigned n3;
        longint unsigned acc;
        longint unsigned best;
        longint unsigned nn_dist;
        bit              raw;
        bit              found;
        out_t            e;
        if (set_cnt < MAX_POINTS) begin
            set_feat[set_cnt][0] = int'(p.feature_a);
            set_feat[set_cnt][1] = int'(p.feature_b);
            set_feat[set_cnt][2] = int'(p.feature_c);
            set_feat[set_cnt][3] = int'(p.feature_d);
            set_cls[set_cnt] = int'(p.class_id);
            set_cnt++;
        end
        if (!p.final_point) return;
        raw = 0;
        n3 = longint'(set_cnt) * set_cnt * set_cnt;
        for (int f = 0; f < FEATURES; f++) begin
            sum = 0;
            scat[f] = 0;
            for (int i = 0; i < set_cnt; i++) sum += set_feat[i][f];
            for (int i = 0; i < set_cnt; i++) begin
                d = longint'(set_cnt) * set_feat[i][f] - sum;
                scat[f] += d * d;
            end
            if (scat[f] == 0) raw = 1;
        end
        for (int i = 0; i < set_cnt; i++) begin
            found = 0;
            best = 0;
            for (int j = 0; j < set_cnt; j++) begin
                if (j == i || set_cls[j] != set_cls[i]) continue;
                acc = 0;
                for (int f = 0; f < FEATURES; f++) begin
                    dx = longint'(set_feat[i][f]) - set_feat[j][f];
                    if (raw) acc += dx * dx;
                    else acc += frac_div(n3 * longint'(dx * dx), scat[f]);
                end
                if (!found || acc < best) begin
                    best = acc;
                    found = 1;
                end
            end
            nn_dist = found ? int_sqrt(best) : 65535;
            if (nn_dist > 65535) nn_dist = 65535;
            e.point_index      = i[PIDX_W-1:0];
            e.nearest_distance = nn_dist[DIST_W-1:0];
            e.kept             = found && (nn_dist <= keep_lim);
            e.raw_used         = raw;
            e.last_result      = (i + 1 == set_cnt);
            nn_results_q.insert(nn_results_q.size(), e);
        end
        set_cnt = 0;
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (nn_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result for point %0d", m_data.point_index));
            end else begin
                w = nn_results_q.pop_front();
                if (m_data.point_index !== w.point_index)
                    report_mismatch($sformatf("point_index %0d, want %0d",
                        m_data.point_index, w.point_index));
                if (m_data.nearest_distance !== w.nearest_distance)
                    report_mismatch($sformatf("point %0d nearest_distance %0d, want %0d",
                        w.point_index, m_data.nearest_distance, w.nearest_distance));
                if (m_data.kept !== w.kept)
                    report_mismatch($sformatf("point %0d kept %0b, want %0b",
                        w.point_index, m_data.kept, w.kept));
                if (m_data.raw_used !== w.raw_used)
                    report_mismatch($sformatf("point %0d raw_used %0b, want %0b",
                        w.point_index, m_data.raw_used, w.raw_used));
                if (m_data.last_result !== w.last_result)
                    report_mismatch($sformatf("point %0d last_result %0b, want %0b",
                        w.point_index, m_data.last_result, w.last_result));
            end
        end
    end

    function automatic in_t mk_pt(int a, int b, int c, int d, int cls, bit fin);
        in_t p;
        p.feature_a   = FEAT_W'(a);
        p.feature_b   = FEAT_W'(b);
        p.feature_c   = FEAT_W'(c);
        p.feature_d   = FEAT_W'(d);
        p.class_id    = CLASS_W'(cls);
        p.final_point = fin;
        return p;
    endfunction

    function automatic out_t mk_res(int idx, int dist_q, bit kept, bit raw, bit last);
        out_t r;
        r.point_index      = PIDX_W'(idx);
        r.nearest_distance = DIST_W'(dist_q);
        r.kept             = kept;
        r.raw_used         = raw;
        r.last_result      = last;
        return r;
    endfunction

    task automatic add_row(in_t p);
        dir_row_t r;
        r.pt = p;
        r.typed = 0;
        dir_tab.insert(dir_tab.size(), r);
    endtask

    task automatic send_point(in_t p);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        predict_nearest(p);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (nn_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= DIST_W'(v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        keep_lim = v;
        @(posedge aclk);
    endtask

    task automatic run_table();
        foreach (dir_tab[k]) begin
            send_point(dir_tab[k].pt);
            if (dir_tab[k].typed) nn_results_q[nn_results_q.size()-1] = dir_tab[k].want;
        end
    endtask

    task automatic run_random_set(int n);
        int kind[4];
        int cval[4];
        int center[4];
        int spread;
        int ncls;
        int cbase;
        int v[4];
        spread = $urandom_range(1) ? 64 : 4096;
        ncls   = $urandom_range(1, 4);
        cbase  = $urandom_range(7);
        for (int f = 0; f < 4; f++) begin
            kind[f]   = $urandom_range(9);
            cval[f]   = $urandom_range(65535);
            center[f] = int'($urandom_range(40000)) - 20000;
        end
        for (int k = 0; k < n; k++) begin
            for (int f = 0; f < 4; f++) begin
                if (kind[f] == 0) v[f] = cval[f];
                else if (kind[f] <= 3) v[f] = $urandom_range(65535);
                else if (kind[f] == 4) v[f] = $urandom_range(1) ? -32768 : 32767;
                else v[f] = center[f] + int'($urandom_range(2 * spread)) - spread;
            end
            send_point(mk_pt(v[0], v[1], v[2], v[3], (cbase + $urandom_range(ncls - 1)) % 8,
                k == n - 1));
        end
    endtask

    initial begin
        dir_row_t r;
        int       lim;
        aresetn     = 0;
        s_valid     = 0;
        s_data      = '0;
        m_ready     = 0;
        cfg_wr_en   = 0;
        cfg_wr_data = '0;
        err_cnt     = 0;
        hold_left   = 0;
        items_sent  = 0;
        set_cnt     = 0;
        keep_lim    = int'(KEEP_RESET);
        send_idle   = 18;
        recv_idle   = 54;

        r.typed = 1;
        r.pt = mk_pt(-32768, -32768, -32768, -32768, 0, 1);
        r.want = mk_res(0, 65535, 0, 1, 1);
        dir_tab.insert(dir_tab.size(), r);
        r.pt = mk_pt(32767, 32767, 32767, 32767, 7, 1);
        dir_tab.insert(dir_tab.size(), r);
        add_row(mk_pt(100, -100, 5, 7, 3, 0));
        add_row(mk_pt(100, -100, 5, 7, 3, 1));
        add_row(mk_pt(-32768, -32768, -32768, -32768, 7, 0));
        add_row(mk_pt(32767, 32767, 32767, 32767, 7, 1));
        add_row(mk_pt(0, -32768, -32768, -32768, 5, 0));
        add_row(mk_pt(0, 32767, 32767, 32767, 5, 1));
        add_row(mk_pt(256, 0, 10, 50, 1, 0));
        add_row(mk_pt(300, 10, -20, 50, 1, 0));
        add_row(mk_pt(-512, 20, 30, 50, 2, 0));
        add_row(mk_pt(-500, 30, 40, 50, 2, 1));
        add_row(mk_pt(256, 512, -256, 0, 4, 0));
        add_row(mk_pt(300, 500, -200, 64, 4, 0));
        add_row(mk_pt(-1000, 20, 900, -64, 6, 0));
        add_row(mk_pt(260, 510, -250, 3, 4, 0));
        add_row(mk_pt(12000, -9000, 77, 1, 4, 1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_table();
        drain_results();
        write_limit(65535);
        run_table();
        drain_results();
        write_limit(0);
        run_table();
        drain_results();
        write_limit(int'(KEEP_RESET));

        while (items_sent < 400) begin
            if (items_sent > 300) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (items_sent > 150) begin
                send_idle = 54;
                recv_idle = 18;
            end
            if ($urandom_range(7) == 0) begin
                drain_results();
                case ($urandom_range(3))
                    0: lim = 0;
                    1: lim = 65535;
                    2: lim = $urandom_range(65535);
                    default: lim = $urandom_range(1024);
                endcase
                write_limit(lim);
            end
            if ($urandom_range(15) == 0) run_random_set($urandom_range(10, 24));
            else run_random_set($urandom_range(1, 8));
            if (items_sent > 200 && items_sent < 225) begin
                hold_left = 600;
                run_random_set(12);
                run_random_set(4);
            end
        end

        drain_results();
        run_random_set(MAX_POINTS + 2);
        drain_results();
        repeat (50) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/zcnn_pkg.sv
rtl/zcnn_ram.sv
rtl/zcnn_lane.sv
rtl/zcnn_isqrt.sv
rtl/zscore_class_nearest_neighbor.sv
sim/tb.sv
